// File: sv/bsm_pkg.sv
// Shared constants, codes and types of the bytecode stack machine.
`default_nettype none

package bsm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam int LOCAL_SLOTS = 256;
    localparam int LOCAL_AW    = $clog2(LOCAL_SLOTS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] OPC_PUSH  = 8'h01;
    localparam logic [7:0] OPC_ADD   = 8'h02;
    localparam logic [7:0] OPC_STORE = 8'h10;
    localparam logic [7:0] OPC_LOAD  = 8'h11;
    localparam logic [7:0] OPC_RET   = 8'h21;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_OPCODE = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW   = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd4;

    localparam logic CFG_LOCAL_COUNT = 1'b0;
    localparam logic [8:0] LOCAL_COUNT_RESET = 9'd256;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_STORE,
        OP_LOAD,
        OP_RET,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] operand;
    } instr_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// File: sv/bsm_front.sv
// Front end: takes code bytes, gathers operands and issues decoded instructions.
`default_nettype none

module bsm_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire bsm_pkg::q_stat_t q_stat,
    output logic                 push,
    output bsm_pkg::instr_t      push_instr
);
    import bsm_pkg::*;

    op_t         opc_reg, opc_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic        accept;
    logic        emit;
    logic [3:0]  total;
    logic [2:0]  pos;
    logic [63:0] acc_ins;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign total    = (opc_reg == OP_PUSH) ? 4'd8 : 4'd2;
    assign pos      = 3'(total - left_reg);
    assign acc_ins  = acc_reg | ({56'b0, s_tdata} << {pos, 3'b000});

    always_comb begin
        opc_next   = opc_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        push_instr = '{op: OP_BAD, operand: '0};
        if (accept) begin
            if (left_reg == 4'd0) begin
                unique case (s_tdata)
                    OPC_PUSH: begin
                        opc_next  = OP_PUSH;
                        left_next = 4'd8;
                        acc_next  = '0;
                    end
                    OPC_STORE: begin
                        opc_next  = OP_STORE;
                        left_next = 4'd2;
                        acc_next  = '0;
                    end
                    OPC_LOAD: begin
                        opc_next  = OP_LOAD;
                        left_next = 4'd2;
                        acc_next  = '0;
                    end
                    OPC_ADD: begin
                        emit       = 1'b1;
                        push_instr = '{op: OP_ADD, operand: '0};
                    end
                    OPC_RET: begin
                        emit       = 1'b1;
                        push_instr = '{op: OP_RET, operand: '0};
                    end
                    default: begin
                        emit       = 1'b1;
                        push_instr = '{op: OP_BAD, operand: '0};
                    end
                endcase
            end else begin
                acc_next  = acc_ins;
                left_next = left_reg - 4'd1;
                if (left_reg == 4'd1) begin
                    emit       = 1'b1;
                    push_instr = '{op: opc_reg, operand: acc_ins};
                    acc_next   = '0;
                end
            end
        end
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opc_reg  <= OP_BAD;
            left_reg <= 4'd0;
            acc_reg  <= '0;
        end else begin
            opc_reg  <= opc_next;
            left_reg <= left_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/bsm_queue.sv
// Short instruction queue between front and back end.
`default_nettype none

module bsm_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire bsm_pkg::instr_t  push_instr,
    input  wire logic             pop,
    output bsm_pkg::q_stat_t      q_stat,
    output bsm_pkg::instr_t       head
);
    import bsm_pkg::*;

    instr_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign q_stat.valid = (cnt_reg != '0);
    assign q_stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_instr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/bsm_back.sv
// Back end: executes instructions on the stack and locals, holds the result register.
`default_nettype none

module bsm_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bsm_pkg::q_stat_t q_stat,
    input  wire bsm_pkg::instr_t  head,
    output logic                  pop,
    input  wire logic [8:0]       local_count,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [63:0]           m_tdata,
    output logic [2:0]            m_tuser
);
    import bsm_pkg::*;

    typedef enum logic {S_EXEC, S_LOAD} state_t;

    state_t              state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [63:0]         tos_reg, tos_next;
    logic [63:0]         srd_reg, fwd_reg;
    logic                fwd_hit_reg;
    logic [63:0]         lrd_reg;
    logic                lrd_valid_reg;
    logic [LOCAL_SLOTS-1:0] lvalid_reg;
    logic                m_valid_reg;
    logic [63:0]         m_data_reg;
    logic [2:0]          m_user_reg;

    logic [63:0]         smem [STACK_DEPTH];
    logic [63:0]         lmem [LOCAL_SLOTS];

    logic                out_free;
    logic [63:0]         nos;
    logic [15:0]         idx;
    logic [LOCAL_AW-1:0] laddr;
    logic [8:0]          usable;
    logic                idx_bad, sp_empty, sp_full, sp_lt2;
    logic [63:0]         ld_data;
    logic                s_we, l_we, l_re;
    logic [STACK_AW-1:0] s_wa, s_ra;
    logic                res_valid;
    logic [63:0]         res_data;
    logic [2:0]          res_status;

    assign out_free = !m_valid_reg || m_tready;
    assign nos      = fwd_hit_reg ? fwd_reg : srd_reg;
    assign idx      = head.operand[15:0];
    assign laddr    = idx[LOCAL_AW-1:0];
    assign usable   = (local_count > 9'(LOCAL_SLOTS)) ? 9'(LOCAL_SLOTS) : local_count;
    assign idx_bad  = {1'b0, idx} >= {8'b0, usable};
    assign sp_empty = (sp_reg == '0);
    assign sp_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign sp_lt2   = (sp_reg < SP_W'(2));
    assign ld_data  = lrd_valid_reg ? lrd_reg : '0;
    assign s_wa     = STACK_AW'(sp_reg - SP_W'(1));
    assign s_ra     = STACK_AW'(sp_next - SP_W'(2));

    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        tos_next   = tos_reg;
        pop        = 1'b0;
        s_we       = 1'b0;
        l_we       = 1'b0;
        l_re       = 1'b0;
        res_valid  = 1'b0;
        res_data   = '0;
        res_status = ST_OK;
        unique case (state_reg)
            S_LOAD: begin
                pop        = 1'b1;
                s_we       = !sp_empty;
                tos_next   = ld_data;
                sp_next    = sp_reg + SP_W'(1);
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (q_stat.valid && out_free) begin
                    pop = 1'b1;
                    unique case (head.op)
                        OP_PUSH: begin
                            if (sp_full) begin
                                res_valid  = 1'b1;
                                res_status = ST_OVERFLOW;
                                sp_next    = '0;
                            end else begin
                                s_we     = !sp_empty;
                                tos_next = head.operand;
                                sp_next  = sp_reg + SP_W'(1);
                            end
                        end
                        OP_ADD: begin
                            if (sp_lt2) begin
                                res_valid  = 1'b1;
                                res_status = ST_UNDERFLOW;
                                sp_next    = '0;
                            end else begin
                                tos_next = nos + tos_reg;
                                sp_next  = sp_reg - SP_W'(1);
                            end
                        end
                        OP_STORE: begin
                            if (idx_bad) begin
                                res_valid  = 1'b1;
                                res_status = ST_BAD_INDEX;
                                sp_next    = '0;
                            end else if (sp_empty) begin
                                res_valid  = 1'b1;
                                res_status = ST_UNDERFLOW;
                                sp_next    = '0;
                            end else begin
                                l_we     = 1'b1;
                                tos_next = nos;
                                sp_next  = sp_reg - SP_W'(1);
                            end
                        end
                        OP_LOAD: begin
                            if (idx_bad) begin
                                res_valid  = 1'b1;
                                res_status = ST_BAD_INDEX;
                                sp_next    = '0;
                            end else if (sp_full) begin
                                res_valid  = 1'b1;
                                res_status = ST_OVERFLOW;
                                sp_next    = '0;
                            end else begin
                                // local read this cycle, push next
                                pop        = 1'b0;
                                l_re       = 1'b1;
                                state_next = S_LOAD;
                            end
                        end
                        OP_RET: begin
                            res_valid = 1'b1;
                            if (sp_empty) begin
                                res_status = ST_UNDERFLOW;
                                sp_next    = '0;
                            end else begin
                                res_data = tos_reg;
                                tos_next = nos;
                                sp_next  = sp_reg - SP_W'(1);
                            end
                        end
                        default: begin
                            res_valid  = 1'b1;
                            res_status = ST_BAD_OPCODE;
                            sp_next    = '0;
                        end
                    endcase
                end
            end
            default: state_next = S_EXEC;
        endcase
    end

    // stack below the top entry; read data tracks the entry under the top
    always_ff @(posedge aclk) begin
        if (s_we) begin
            smem[s_wa] <= tos_reg;
        end
        srd_reg <= smem[s_ra];
        fwd_reg <= tos_reg;
    end

    always_ff @(posedge aclk) begin
        if (l_we) begin
            lmem[laddr] <= tos_reg;
        end
        if (l_re) begin
            lrd_reg <= lmem[laddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_EXEC;
            sp_reg        <= '0;
            fwd_hit_reg   <= 1'b0;
            lvalid_reg    <= '0;
            lrd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            fwd_hit_reg <= s_we && (s_wa == s_ra);
            if (l_we) begin
                lvalid_reg[laddr] <= 1'b1;
            end
            if (l_re) begin
                lrd_valid_reg <= lvalid_reg[laddr];
            end
            if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (res_valid) begin
            m_data_reg <= res_data;
            m_user_reg <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// File: sv/bytecode_stack_machine_unit.sv
// Top level of the bytecode stack machine: front end, queue, back end, register port.
//
//   Channel  Dir  Ports                          Word
//   s_       in   s_tvalid s_tready s_tdata      code byte
//   m_       out  m_tvalid m_tready m_tdata/user return value, status
//   apb      in   psel penable pwrite paddr ...  local_count at 0x0
//
// One code byte per cycle while the queue is not full. Push, add, return and store
// finish in the back end's execute state; load also passes the load state (local
// store read is registered); the four-entry queue absorbs that. Reset is
// synchronous; local valid bits clear at once, no clearing pass. A stalled result
// holds the back end only; the front end keeps taking bytes until the queue fills.
`default_nettype none

module bytecode_stack_machine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] code_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] return_value
    output logic [2:0]       m_tuser,   // [2:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bsm_pkg::*;

    logic [8:0] local_count_reg;
    q_stat_t    q_stat;
    instr_t     push_instr, head;
    logic       push, pop;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_LOCAL_COUNT);
    assign prdata = (paddr[2] == CFG_LOCAL_COUNT) ? {23'b0, local_count_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_count_reg <= LOCAL_COUNT_RESET;
        end else if (cfg_wr) begin
            local_count_reg <= pwdata[8:0];
        end
    end

    bsm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_stat     (q_stat),
        .push       (push),
        .push_instr (push_instr)
    );

    bsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_instr (push_instr),
        .pop        (pop),
        .q_stat     (q_stat),
        .head       (head)
    );

    bsm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_stat      (q_stat),
        .head        (head),
        .pop         (pop),
        .local_count (local_count_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// File: sv/bsm_checker.sv
// Port-level checks of the bytecode stack machine, bound to the top level.
`default_nettype none

module bsm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);
    import bsm_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == 64'd0))
        else $error("error result with non-zero value");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_BAD_INDEX))
        else $error("status code out of range");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && (paddr[2] == CFG_LOCAL_COUNT)
        |=> (paddr[2] != CFG_LOCAL_COUNT) || (prdata == {23'b0, $past(pwdata[8:0])}))
        else $error("local_count readback mismatch");

endmodule

bind bytecode_stack_machine_unit bsm_checker u_bsm_checker (.*);

`default_nettype wire
